// ===== rtl/core/fsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fsu_pkg;

  localparam int DATA_DEPTH_DEF   = 64;
  localparam int RETURN_DEPTH_DEF = 32;
  localparam int WORD_W           = 64;
  localparam int CMD_W            = 5;

  typedef enum logic [4:0] {
    CMD_PUSH    = 5'd0,
    CMD_DUP     = 5'd1,
    CMD_SWAP    = 5'd2,
    CMD_OVER    = 5'd3,
    CMD_ROT     = 5'd4,
    CMD_DROP    = 5'd5,
    CMD_DROP2   = 5'd6,
    CMD_PICK    = 5'd7,
    CMD_ADD     = 5'd8,
    CMD_SUB     = 5'd9,
    CMD_MUL     = 5'd10,
    CMD_DIV     = 5'd11,
    CMD_MOD     = 5'd12,
    CMD_AND     = 5'd13,
    CMD_OR      = 5'd14,
    CMD_NOT     = 5'd15,
    CMD_GT      = 5'd16,
    CMD_LT      = 5'd17,
    CMD_EQ      = 5'd18,
    CMD_TRUE    = 5'd19,
    CMD_FALSE   = 5'd20,
    CMD_TO_R    = 5'd21,
    CMD_R_FROM  = 5'd22,
    CMD_R_FETCH = 5'd23,
    CMD_DOT     = 5'd24
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_CALC,
    S_WAIT,
    S_WR,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MD_MUL,
    MD_DIV,
    MD_MOD
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

  // Inverted Forth flags: zero means true.
  localparam logic [WORD_W-1:0] FLAG_TRUE  = '0;
  localparam logic [WORD_W-1:0] FLAG_FALSE = {{(WORD_W-1){1'b0}}, 1'b1};

endpackage

`default_nettype wire

// ===== rtl/core/fsu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fsu_cmd_if;
  logic               valid;
  logic               ready;
  logic [4:0]         command;
  logic signed [63:0] literal;

  modport source (output valid, output command, output literal, input ready);
  modport sink   (input valid, input command, input literal, output ready);
endinterface

interface fsu_res_if #(
  parameter int DLW = 7,
  parameter int RLW = 6
);
  logic               valid;
  logic               ready;
  logic signed [63:0] popped_value;
  logic signed [63:0] top_value;
  logic [DLW-1:0]     data_count;
  logic [RLW-1:0]     return_count;
  logic [1:0]         status;

  modport source (output valid, output popped_value, output top_value, output data_count,
                  output return_count, output status, input ready);
  modport sink   (input valid, input popped_value, input top_value, input data_count,
                  input return_count, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fsu_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fsu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/fsu_muldiv.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fsu_muldiv (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire fsu_pkg::md_req_t req,
  input  wire logic [63:0]     a,
  input  wire logic [63:0]     b,
  output logic                 done,
  output logic [63:0]          result
);
  import fsu_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  md_op_t      op_r;
  logic [63:0] acc;
  logic [63:0] mc;
  logic [63:0] mp;
  logic        neg_q;
  logic        neg_r;
  logic [63:0] rem_sh;
  logic        ge;

  // One bit per cycle: shift-add for the product, restoring steps for the quotient.
  assign rem_sh = {acc[62:0], mc[63]};
  assign ge     = (rem_sh >= mp);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        op_r  <= req.op;
        neg_q <= a[63] ^ b[63];
        neg_r <= a[63];
        if (req.op == MD_MUL) begin
          acc <= '0;
          mc  <= a;
          mp  <= b;
        end else begin
          acc <= '0;
          mc  <= a[63] ? (64'd0 - a) : a;
          mp  <= b[63] ? (64'd0 - b) : b;
        end
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (op_r == MD_MUL) begin
          if (mp[0]) begin
            acc <= acc + mc;
          end
          mc <= {mc[62:0], 1'b0};
          mp <= {1'b0, mp[63:1]};
        end else begin
          mc  <= {mc[62:0], ge};
          acc <= ge ? (rem_sh - mp) : rem_sh;
        end
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    unique case (op_r)
      MD_MUL:  result = acc;
      MD_DIV:  result = neg_q ? (64'd0 - mc) : mc;
      MD_MOD:  result = neg_r ? (64'd0 - acc) : acc;
      default: result = acc;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/forth_stack_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A rejected command or a no-op goes straight to the result state; stack words pass through
// the read, calculate and write states (SWAP makes two writes and ROT three), and *, / and
// MOD also wait on an iterative unit that computes one bit per cycle.
// One command at a time; the next is taken the cycle after the result is loaded, and a
// stalled result transfer holds it.
// Reset (synchronous, active high) empties both stacks; the stack memories are not cleared.
module forth_stack_unit #(
  parameter int DATA_DEPTH   = fsu_pkg::DATA_DEPTH_DEF,
  parameter int RETURN_DEPTH = fsu_pkg::RETURN_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  fsu_cmd_if.sink  cmd,
  fsu_res_if.source res
);
  import fsu_pkg::*;

  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int DLW = $clog2(DATA_DEPTH + 1);
  localparam int RAW = $clog2(RETURN_DEPTH);
  localparam int RLW = $clog2(RETURN_DEPTH + 1);
  localparam logic [DLW-1:0] D_FULL = DLW'(DATA_DEPTH);
  localparam logic [RLW-1:0] R_FULL = RLW'(RETURN_DEPTH);

  state_t      state, state_next;
  cmd_t        cmd_r;
  logic [63:0] lit_r;
  status_t     st_r;
  status_t     chk;

  // The top of the data stack is held in a register; the memory keeps every entry.
  logic [63:0]    top_r;
  logic [DLW-1:0] level;
  logic [RLW-1:0] rlevel;

  logic [63:0] x_r;
  logic [63:0] y_r;
  logic [63:0] rx_r;
  logic [63:0] res_r;
  logic [1:0]  wcnt;
  logic [1:0]  nw;

  logic [DLW-1:0] d_raddr_full;
  logic [DAW-1:0] d_raddr;
  logic [63:0]    d_rdata;
  logic           d_we;
  logic [DLW-1:0] d_waddr_full;
  logic [63:0]    d_wdata;
  logic           r_we;
  logic [RAW-1:0] r_raddr;
  logic [63:0]    r_rdata;

  logic [DLW-1:0] addr_a;
  logic [DLW-1:0] addr_b;
  logic [63:0]    alu_res;
  logic [63:0]    not_res;
  logic [63:0]    push_val;
  logic           accept;
  logic           is_nop;
  logic           is_md;
  md_req_t        md_req;
  logic           md_done;
  logic [63:0]    md_res;

  logic [63:0]    new_top;
  logic [DLW-1:0] new_level;
  logic [RLW-1:0] new_rlevel;
  logic [63:0]    popped;
  logic           load_out;

  logic               ov;
  logic signed [63:0] o_popped;
  logic signed [63:0] o_top;
  logic [DLW-1:0]     o_dcount;
  logic [RLW-1:0]     o_rcount;
  status_t            o_status;

  fsu_ram #(.WIDTH(64), .DEPTH(DATA_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr_full[DAW-1:0]),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  fsu_ram #(.WIDTH(64), .DEPTH(RETURN_DEPTH)) u_return_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (rlevel[RAW-1:0]),
    .wdata (top_r),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  fsu_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .a      (x_r),
    .b      (top_r),
    .done   (md_done),
    .result (md_res)
  );

  assign accept = cmd.valid && cmd.ready;
  assign is_md  = (cmd_r == CMD_MUL) || (cmd_r == CMD_DIV) || (cmd_r == CMD_MOD);

  // Checks on an arriving command: underflow first, then overflow, then division by zero.
  always_comb begin
    chk    = ST_OK;
    is_nop = 1'b0;
    unique case (cmd_t'(cmd.command))
      CMD_PUSH, CMD_TRUE, CMD_FALSE: begin
        if (level == D_FULL) chk = ST_OVER;
      end
      CMD_DUP: begin
        if (level < DLW'(1)) chk = ST_UNDER;
        else if (level == D_FULL) chk = ST_OVER;
      end
      CMD_OVER: begin
        if (level < DLW'(2)) chk = ST_UNDER;
        else if (level == D_FULL) chk = ST_OVER;
      end
      CMD_SWAP, CMD_DROP2: begin
        if (level < DLW'(2)) chk = ST_UNDER;
      end
      CMD_ROT: begin
        if (level < DLW'(3)) chk = ST_UNDER;
      end
      CMD_DROP, CMD_DOT, CMD_NOT: begin
        if (level < DLW'(1)) chk = ST_UNDER;
      end
      CMD_PICK: begin
        if (level < DLW'(1)) chk = ST_UNDER;
        else if (top_r[63] || (top_r >= (64'(level) - 64'd1))) chk = ST_UNDER;
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_AND, CMD_OR, CMD_GT, CMD_LT, CMD_EQ: begin
        if (level < DLW'(2)) chk = ST_UNDER;
      end
      CMD_DIV, CMD_MOD: begin
        if (level < DLW'(2)) chk = ST_UNDER;
        else if (top_r == 64'd0) chk = ST_DIVZ;
      end
      CMD_TO_R: begin
        if (level < DLW'(1)) chk = ST_UNDER;
        else if (rlevel == R_FULL) chk = ST_OVER;
      end
      CMD_R_FROM, CMD_R_FETCH: begin
        if (rlevel < RLW'(1)) chk = ST_UNDER;
        else if (level == D_FULL) chk = ST_OVER;
      end
      default: is_nop = 1'b1;
    endcase
  end

  // Read addresses: the first read fetches the second entry (or the picked or third
  // entry), the second read the second entry for rot.
  always_comb begin
    unique case (cmd_r)
      CMD_ROT, CMD_DROP2: addr_a = level - DLW'(3);
      CMD_PICK:           addr_a = level - DLW'(2) - top_r[DLW-1:0];
      default:            addr_a = level - DLW'(2);
    endcase
    addr_b = level - DLW'(2);
  end

  assign d_raddr_full = (state == S_RDA) ? addr_a : addr_b;
  assign d_raddr      = d_raddr_full[DAW-1:0];
  assign r_raddr      = RAW'(rlevel - RLW'(1));

  // Combinational operators; the second entry is the left operand.
  always_comb begin
    unique case (cmd_r)
      CMD_ADD: alu_res = x_r + top_r;
      CMD_SUB: alu_res = x_r - top_r;
      CMD_AND: alu_res = ((x_r == 64'd0) && (top_r == 64'd0)) ? FLAG_TRUE : FLAG_FALSE;
      CMD_OR:  alu_res = ((x_r == 64'd0) || (top_r == 64'd0)) ? FLAG_TRUE : FLAG_FALSE;
      CMD_GT:  alu_res = ($signed(x_r) > $signed(top_r)) ? FLAG_TRUE : FLAG_FALSE;
      CMD_LT:  alu_res = ($signed(x_r) < $signed(top_r)) ? FLAG_TRUE : FLAG_FALSE;
      default: alu_res = (x_r == top_r) ? FLAG_TRUE : FLAG_FALSE;
    endcase
  end

  assign not_res = (top_r == 64'd0) ? FLAG_FALSE : FLAG_TRUE;

  always_comb begin
    unique case (cmd_r)
      CMD_TRUE:  push_val = FLAG_TRUE;
      CMD_FALSE: push_val = FLAG_FALSE;
      default:   push_val = lit_r;
    endcase
  end

  // Write schedule: rot needs three data writes, swap two, the rest one step
  // (drop-like words and >r use that step for no data write).
  always_comb begin
    nw           = 2'd1;
    d_waddr_full = level;
    d_wdata      = top_r;
    d_we         = 1'b0;
    r_we         = 1'b0;
    unique case (cmd_r)
      CMD_PUSH, CMD_TRUE, CMD_FALSE: begin
        d_we = 1'b1; d_wdata = push_val;
      end
      CMD_DUP:  d_we = 1'b1;
      CMD_OVER: begin
        d_we = 1'b1; d_wdata = x_r;
      end
      CMD_SWAP: begin
        nw   = 2'd2;
        d_we = 1'b1;
        if (wcnt == 2'd0) begin
          d_waddr_full = level - DLW'(2);
          d_wdata      = top_r;
        end else begin
          d_waddr_full = level - DLW'(1);
          d_wdata      = x_r;
        end
      end
      CMD_ROT: begin
        nw   = 2'd3;
        d_we = 1'b1;
        if (wcnt == 2'd0) begin
          d_waddr_full = level - DLW'(3);
          d_wdata      = y_r;
        end else if (wcnt == 2'd1) begin
          d_waddr_full = level - DLW'(2);
          d_wdata      = top_r;
        end else begin
          d_waddr_full = level - DLW'(1);
          d_wdata      = x_r;
        end
      end
      CMD_PICK: begin
        d_we = 1'b1; d_waddr_full = level - DLW'(1); d_wdata = x_r;
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD,
      CMD_AND, CMD_OR, CMD_GT, CMD_LT, CMD_EQ: begin
        d_we = 1'b1; d_waddr_full = level - DLW'(2); d_wdata = res_r;
      end
      CMD_NOT: begin
        d_we = 1'b1; d_waddr_full = level - DLW'(1); d_wdata = not_res;
      end
      CMD_R_FROM, CMD_R_FETCH: begin
        d_we = 1'b1; d_wdata = rx_r;
      end
      CMD_TO_R: r_we = 1'b1;
      default: ;
    endcase
    if (state != S_WR) begin
      d_we = 1'b0;
      r_we = 1'b0;
    end
  end

  // Stack state after a successful command.
  always_comb begin
    new_top    = top_r;
    new_level  = level;
    new_rlevel = rlevel;
    popped     = 64'd0;
    if (st_r == ST_OK) begin
      unique case (cmd_r)
        CMD_PUSH, CMD_TRUE, CMD_FALSE: begin
          new_top = push_val; new_level = level + DLW'(1);
        end
        CMD_DUP: new_level = level + DLW'(1);
        CMD_OVER: begin
          new_top = x_r; new_level = level + DLW'(1);
        end
        CMD_SWAP, CMD_ROT, CMD_PICK: new_top = x_r;
        CMD_DROP: begin
          new_top = x_r; new_level = level - DLW'(1);
        end
        CMD_DOT: begin
          new_top = x_r; new_level = level - DLW'(1); popped = top_r;
        end
        CMD_DROP2: begin
          new_top = x_r; new_level = level - DLW'(2);
        end
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD,
        CMD_AND, CMD_OR, CMD_GT, CMD_LT, CMD_EQ: begin
          new_top = res_r; new_level = level - DLW'(1);
        end
        CMD_NOT: new_top = not_res;
        CMD_TO_R: begin
          new_top = x_r; new_level = level - DLW'(1); new_rlevel = rlevel + RLW'(1);
        end
        CMD_R_FROM: begin
          new_top = rx_r; new_level = level + DLW'(1); new_rlevel = rlevel - RLW'(1);
        end
        CMD_R_FETCH: begin
          new_top = rx_r; new_level = level + DLW'(1);
        end
        default: ;
      endcase
    end
  end

  assign load_out = (state == S_DONE) && (!ov || res.ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = ((chk == ST_OK) && !is_nop) ? S_RDA : S_DONE;
        end
      end
      S_RDA:  state_next = S_RDB;
      S_RDB:  state_next = S_CALC;
      S_CALC: state_next = is_md ? S_WAIT : S_WR;
      S_WAIT: if (md_done) state_next = S_WR;
      S_WR:   if (wcnt == (nw - 2'd1)) state_next = S_DONE;
      S_DONE: if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    cmd.ready    = (state == S_IDLE);
    md_req.start = (state == S_CALC) && is_md;
    unique case (cmd_r)
      CMD_DIV: md_req.op = MD_DIV;
      CMD_MOD: md_req.op = MD_MOD;
      default: md_req.op = MD_MUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      level  <= '0;
      rlevel <= '0;
      ov     <= 1'b0;
      wcnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cmd_r <= cmd_t'(cmd.command);
        lit_r <= cmd.literal;
        st_r  <= chk;
        wcnt  <= '0;
      end
      if (state == S_RDB) begin
        x_r  <= d_rdata;
        rx_r <= r_rdata;
      end
      if (state == S_CALC) begin
        y_r   <= d_rdata;
        res_r <= alu_res;
      end
      if ((state == S_WAIT) && md_done) begin
        res_r <= md_res;
      end
      if (state == S_WR) begin
        wcnt <= wcnt + 2'd1;
      end
      if (load_out) begin
        top_r    <= new_top;
        level    <= new_level;
        rlevel   <= new_rlevel;
        ov       <= 1'b1;
        o_popped <= popped;
        o_top    <= (new_level != '0) ? new_top : 64'd0;
        o_dcount <= new_level;
        o_rcount <= new_rlevel;
        o_status <= st_r;
      end else if (res.ready) begin
        ov <= 1'b0;
      end
    end
  end

  assign res.valid        = ov;
  assign res.popped_value = o_popped;
  assign res.top_value    = o_top;
  assign res.data_count   = o_dcount;
  assign res.return_count = o_rcount;
  assign res.status       = o_status;

endmodule

`default_nettype wire
